FILE: rtl/core/trv_pkg.sv
package trv_pkg;

    // Operation codes carried in the op field of an input item.
    typedef enum logic [0:0] {
        OP_RESEED = 1'b0,
        OP_NEXT   = 1'b1
    } t_op;

    // Register selects, taken from paddr[3] (registers sit at 8-byte steps).
    localparam logic REG_COEFF_BITS = 1'b0;
    localparam logic REG_MODULUS    = 1'b1;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned COEFF_W     = 63;
    localparam int unsigned CBITS_W     = 6;
    localparam int unsigned BLANK_ROUNDS = 18;
    localparam int unsigned CNT_W       = $clog2(BLANK_ROUNDS + 1);

    localparam logic [WORD_W-1:0]  RESEED_CONST  = 64'h0000_7000_0000_0000;
    localparam logic [CBITS_W-1:0] COEFF_BITS_RST = 6'd54;
    localparam logic [COEFF_W-1:0] MODULUS_RST    = 63'd9007199256051713;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] seed_value;
        logic [WORD_W-1:0] sequence_number;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]  keystream_word;
        logic [COEFF_W-1:0] coefficient;
    } t_out_item;

    // Six-word state: a recent and an older word for each of the three registers.
    typedef struct packed {
        logic [WORD_W-1:0] first_recent;
        logic [WORD_W-1:0] first_older;
        logic [WORD_W-1:0] second_recent;
        logic [WORD_W-1:0] second_older;
        logic [WORD_W-1:0] third_recent;
        logic [WORD_W-1:0] third_older;
    } t_state;

    typedef struct packed {
        t_state            next_state;
        logic [WORD_W-1:0] ks;
    } t_round;

    // Register bits at a given lag: the older word's low bits above the recent word's high bits.
    function automatic logic [WORD_W-1:0] f_tap(input logic [WORD_W-1:0] older,
                                                input logic [WORD_W-1:0] recent,
                                                input int unsigned k);
        logic [2*WORD_W-1:0] cat;
        cat = {older, recent} >> k;
        return cat[WORD_W-1:0];
    endfunction

    // One 64-bit round: keystream word and the advanced state.
    function automatic t_round f_round(input t_state s);
        logic [WORD_W-1:0] a66, a93, a91, a92, a69;
        logic [WORD_W-1:0] b162, b177, b171, b175, b176;
        logic [WORD_W-1:0] c243, c288, c264, c286, c287;
        logic [WORD_W-1:0] u1, u2, u3;
        t_round r;
        a66  = f_tap(s.first_older, s.first_recent, 2);
        a93  = f_tap(s.first_older, s.first_recent, 29);
        a91  = f_tap(s.first_older, s.first_recent, 27);
        a92  = f_tap(s.first_older, s.first_recent, 28);
        a69  = f_tap(s.first_older, s.first_recent, 5);
        b162 = f_tap(s.second_older, s.second_recent, 5);
        b177 = f_tap(s.second_older, s.second_recent, 20);
        b171 = f_tap(s.second_older, s.second_recent, 14);
        b175 = f_tap(s.second_older, s.second_recent, 18);
        b176 = f_tap(s.second_older, s.second_recent, 19);
        c243 = f_tap(s.third_older, s.third_recent, 2);
        c288 = f_tap(s.third_older, s.third_recent, 47);
        c264 = f_tap(s.third_older, s.third_recent, 23);
        c286 = f_tap(s.third_older, s.third_recent, 45);
        c287 = f_tap(s.third_older, s.third_recent, 46);
        u1 = a66 ^ a93;
        u2 = b162 ^ b177;
        u3 = c243 ^ c288;
        r.ks = u1 ^ u2 ^ u3;
        u1 = u1 ^ (a91 & a92) ^ b171;
        u2 = u2 ^ (b175 & b176) ^ c264;
        u3 = u3 ^ (c286 & c287) ^ a69;
        r.next_state.first_older  = s.first_recent;
        r.next_state.first_recent = u3;
        r.next_state.second_older  = s.second_recent;
        r.next_state.second_recent = u1;
        r.next_state.third_older  = s.third_recent;
        r.next_state.third_recent = u2;
        return r;
    endfunction

    // Mask with the low bits set below the configured count.
    function automatic logic [COEFF_W-1:0] f_mask(input logic [CBITS_W-1:0] bits);
        logic [COEFF_W-1:0] m;
        for (int i = 0; i < COEFF_W; i++) begin
            m[i] = (i < 32'(bits));
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/trv_in_if.sv
interface trv_in_if;
    logic              valid;
    logic              ready;
    trv_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/trv_out_if.sv
interface trv_out_if;
    logic               valid;
    logic               ready;
    trv_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/trivium_word_prng_coeff_sampler.sv
// Channel   Direction  Payload                                  Transfer when
// i_in      sink       op, seed_value, sequence_number          valid & ready
// o_out     source     keystream_word, coefficient              valid & ready
// APB       slave      coeff_bits @0x0, modulus @0x8 (64-bit)   psel & penable & pwrite
//
// A next item advances the state one round; its result is registered in the output or skid stage.
// A reseed item loads the state, then runs 18 blank rounds through the one round unit,
// during which i_in.ready is low.
// Reset (synchronous, active low) clears the state words, restores the register defaults
// and empties the output register and skid stage.
// A stalled output keeps accepting until the skid stage holds a second result.
module trivium_word_prng_coeff_sampler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    trv_in_if.sink               i_in,
    trv_out_if.source            o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic [trv_pkg::CBITS_W-1:0] r_coeff_bits;
    logic [trv_pkg::COEFF_W-1:0] r_modulus;
    trv_pkg::t_state             r_state, n_state;
    logic [trv_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        r_skid_valid, n_skid_valid;
    trv_pkg::t_out_item          r_out_item, n_out_item;
    trv_pkg::t_out_item          r_skid_item, n_skid_item;

    trv_pkg::t_round             round;
    trv_pkg::t_out_item          result;
    logic [trv_pkg::COEFF_W-1:0] masked;
    logic                        in_acc;
    logic                        new_res;
    logic                        drain;
    logic                        cfg_wr;

    // Configuration port: writes take effect on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_bits <= trv_pkg::COEFF_BITS_RST;
            r_modulus    <= trv_pkg::MODULUS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                trv_pkg::REG_COEFF_BITS: r_coeff_bits <= pwdata[trv_pkg::CBITS_W-1:0];
                trv_pkg::REG_MODULUS:    r_modulus    <= pwdata[trv_pkg::COEFF_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            trv_pkg::REG_COEFF_BITS: prdata = {{(64-trv_pkg::CBITS_W){1'b0}}, r_coeff_bits};
            trv_pkg::REG_MODULUS:    prdata = {{(64-trv_pkg::COEFF_W){1'b0}}, r_modulus};
        endcase
    end

    // Handshake: stop only while blank rounds run or both result slots are full.
    assign i_in.ready = (r_cnt == '0) && !r_skid_valid;
    assign in_acc     = i_in.valid && i_in.ready;
    assign new_res    = in_acc && (i_in.payload.op == trv_pkg::OP_NEXT);
    assign drain      = r_out_valid && o_out.ready;

    // Round unit and coefficient: mask, then subtract the modulus once if the masked value is not below it.
    assign round  = trv_pkg::f_round(r_state);
    assign masked = round.ks[trv_pkg::COEFF_W-1:0] & trv_pkg::f_mask(r_coeff_bits);

    always_comb begin
        result.keystream_word = round.ks;
        result.coefficient    = (masked < r_modulus) ? masked : (masked - r_modulus);
    end

    // State update: reseed load, blank rounds, or one round per next item.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (r_cnt != '0) begin
            n_state = round.next_state;
            n_cnt   = r_cnt - 1'b1;
        end else if (in_acc) begin
            if (i_in.payload.op == trv_pkg::OP_RESEED) begin
                n_state.first_recent  = i_in.payload.seed_value;
                n_state.first_older   = '0;
                n_state.second_recent = i_in.payload.sequence_number;
                n_state.second_older  = '0;
                n_state.third_recent  = '0;
                n_state.third_older   = trv_pkg::RESEED_CONST;
                n_cnt = trv_pkg::CNT_W'(trv_pkg::BLANK_ROUNDS);
            end else begin
                n_state = round.next_state;
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (!r_out_valid || drain) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else if (new_res) begin
                n_out_valid = 1'b1;
                n_out_item  = result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (new_res) begin
            n_skid_valid = 1'b1;
            n_skid_item  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    // The skid stage only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    // A reseed starts the full run of blank rounds.
    a_reseed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.payload.op == trv_pkg::OP_RESEED))
        |=> (r_cnt == trv_pkg::CNT_W'(trv_pkg::BLANK_ROUNDS)))
        else $error("reseed did not start the blank rounds");

    // No transfer on the input while blank rounds run.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> !i_in.ready)
        else $error("input ready during blank rounds");

    // A result produced against a stalled output lands in the skid stage.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_res && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result lost behind a stalled output");

endmodule
